// File: design/smoothed_category_histogram_assert.svh
// Assertion macros for the category histogram block and its checker.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef SMOOTHED_CATEGORY_HISTOGRAM_ASSERT_SVH
`define SMOOTHED_CATEGORY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCH_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("sch assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("sch assertion failed");

`endif

// File: design/sch_pkg.sv
// Shared constants and request codes for the category histogram.
// Used by the top level and by its port checker; depends on nothing.
package sch_pkg;

	localparam int NUM_GENES_DEF = 1024;

	localparam int REQ_W    = 2;
	localparam int ID_W     = 16;
	localparam int WEIGHT_W = 16;
	localparam int SMOOTH_W = 16;
	localparam int PROB_W   = 17;
	localparam int DIST_W   = 11;
	localparam int CNT_W    = 32;
	localparam int DEN_W    = CNT_W + 1;

	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	localparam logic [PROB_W-1:0]   PROB_ONE     = 17'd65536;
	localparam logic [DIST_W-1:0]   DISTINCT_MAX = 11'd2047;
	localparam logic [SMOOTH_W-1:0] SMOOTH_RST   = 16'd32768;

endpackage

// File: design/smoothed_category_histogram.sv
// Weighted category histogram with smoothed Q1.16 probability queries.
// Depends on sch_pkg; count storage is an internal single-port-write memory.
//
//  channel | signals                                        | dir | handshake
//  --------+------------------------------------------------+-----+------------------
//  input   | req_type, category_id, weight, use_smooth      | in  | in_valid/in_ready
//  result  | probability, distinct_categories               | out | out_valid/out_ready
//  config  | cfg_wr_data (smooth_amount)                    | in  | cfg_wr_en, no wait
//
// Steps: an add reads, writes the count, then updates the total; a query builds
// the denominator, checks it, then runs the 17-step restoring divider on the
// shared add/sub unit; missing-id and empty-histogram queries skip all of that.
// Clear and reset both run a sweep over all NUM_GENES entries of the count memory,
// one entry a cycle, with in_ready low; config writes are still taken.
// A finished result waits in the output register while the next beat is taken.
module smoothed_category_histogram #(
	parameter int NUM_GENES = sch_pkg::NUM_GENES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sch_pkg::REQ_W-1:0]          req_type,
	input  logic signed [sch_pkg::ID_W-1:0]    category_id,
	input  logic [sch_pkg::WEIGHT_W-1:0]       weight,
	input  logic                               use_smooth,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sch_pkg::PROB_W-1:0]         probability,
	output logic [sch_pkg::DIST_W-1:0]         distinct_categories,
	input  logic                               cfg_wr_en,
	input  logic [sch_pkg::SMOOTH_W-1:0]       cfg_wr_data
);
	import sch_pkg::*;

	localparam int AW = (NUM_GENES > 1) ? $clog2(NUM_GENES) : 1;
	localparam int ALU_W = DEN_W + 1;
	localparam int CNT_BW = $clog2(PROB_W);
	localparam logic [ID_W-1:0] NG_ID = ID_W'(NUM_GENES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_GENES - 1);
	localparam int EMPTY_INT = (65536 + NUM_GENES / 2) / NUM_GENES;
	localparam logic [PROB_W-1:0] EMPTY_P = PROB_W'(EMPTY_INT);
	localparam logic [CNT_BW-1:0] LAST_STEP = CNT_BW'(PROB_W - 1);

	// sequencer codes
	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_ADD_CNT = 4'd2;
	localparam logic [3:0] S_ADD_TOT = 4'd3;
	localparam logic [3:0] S_Q_DEN   = 4'd4;
	localparam logic [3:0] S_Q_CHK   = 4'd5;
	localparam logic [3:0] S_Q_ADJ   = 4'd6;
	localparam logic [3:0] S_Q_DIV   = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]          state_q;
	logic [AW-1:0]       clr_addr_q;
	logic [CNT_W-1:0]    total_q;
	logic [DIST_W-1:0]   distinct_q;
	logic [SMOOTH_W-1:0] smooth_q;
	logic                out_valid_q;

	// payload registers, no reset
	logic [CNT_W-1:0]    count_mem_q [NUM_GENES];
	logic [CNT_W-1:0]    rd_data_q;
	logic [AW-1:0]       addr_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                smooth_on_q;
	logic                in_range_q;
	logic [CNT_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [PROB_W-1:0]   dl_q;
	logic [PROB_W-1:0]   quo_q;
	logic [CNT_BW-1:0]   step_q;
	logic [PROB_W-1:0]   res_q;
	logic [PROB_W-1:0]   prob_q;
	logic [DIST_W-1:0]   dist_out_q;

	logic                in_fire;
	logic                id_in_range;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [CNT_W-1:0]    mem_wdata;
	logic [ALU_W-1:0]    alu_a;
	logic [ALU_W-1:0]    alu_b;
	logic                alu_sub;
	logic [ALU_W:0]      alu_res;
	logic                alu_borrow;
	logic [CNT_W-1:0]    alu_sat;
	logic [ALU_W-1:0]    rem_shift;
	logic [PROB_W-1:0]   quo_next;
	logic [PROB_W-1:0]   quo_clamped;
	logic [CNT_W-1:0]    cnt_sel;
	logic                cnt_above;
	logic                out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Negative ids are missing; ids at or above the table size are out of range.
	assign id_in_range = !category_id[ID_W-1] && ($unsigned(category_id) < NG_ID);

	// Shared add/sub unit: saturating adds, denominator build, the
	// numerator-above-denominator check, the rounding add and every divider step.
	assign rem_shift = {rem_q, dl_q[PROB_W-1]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_ADD_CNT: begin
				alu_a = ALU_W'(rd_data_q);
				alu_b = ALU_W'(weight_q);
			end
			S_ADD_TOT: begin
				alu_a = ALU_W'(total_q);
				alu_b = ALU_W'(weight_q);
			end
			S_Q_DEN: begin
				alu_a = ALU_W'(total_q);
				alu_b = smooth_on_q ? ALU_W'(smooth_q) : '0;
			end
			S_Q_CHK: begin
				alu_a   = ALU_W'(den_q);
				alu_b   = ALU_W'(num_q);
				alu_sub = 1'b1;
			end
			S_Q_ADJ: begin
				alu_a = ALU_W'(num_q);
				alu_b = ALU_W'(den_q[DEN_W-1:PROB_W]);
			end
			S_Q_DIV: begin
				alu_a   = rem_shift;
				alu_b   = ALU_W'(den_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_res[ALU_W];
	assign alu_sat    = alu_res[CNT_W] ? '1 : alu_res[CNT_W-1:0];

	// Smoothing floor: with smoothing on, the numerator is the larger of count and smooth_amount.
	assign cnt_sel   = in_range_q ? rd_data_q : '0;
	assign cnt_above = (cnt_sel[CNT_W-1:SMOOTH_W] != '0) || (cnt_sel[SMOOTH_W-1:0] > smooth_q);

	assign quo_next    = {quo_q[PROB_W-2:0], !alu_borrow};
	assign quo_clamped = (quo_next[PROB_W-1] && (quo_next[PROB_W-2:0] != '0)) ? PROB_ONE
	                                                                          : quo_next;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Count memory: one write port (sweep or add), one registered read port.
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_ADD_CNT);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : alu_sat;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem_q[mem_waddr] <= mem_wdata;
		end
		if (in_fire && id_in_range) begin
			rd_data_q <= count_mem_q[category_id[AW-1:0]];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			total_q     <= '0;
			distinct_q  <= '0;
			smooth_q    <= SMOOTH_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				smooth_q <= cfg_wr_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					// sweep one entry a cycle
					if (clr_addr_q == LAST_ADDR) begin
						clr_addr_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (req_type)
							REQ_CLEAR: begin
								total_q    <= '0;
								distinct_q <= '0;
								clr_addr_q <= '0;
								state_q    <= S_CLEAR;
							end
							REQ_ADD: begin
								// drop missing or out-of-range adds
								if (id_in_range) begin
									state_q <= S_ADD_CNT;
								end
							end
							REQ_QUERY: begin
								if (category_id[ID_W-1] || (total_q == '0)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_Q_DEN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD_CNT: begin
					// first sample into an empty entry, zero weight included
					if ((rd_data_q == '0) && (distinct_q != DISTINCT_MAX)) begin
						distinct_q <= distinct_q + DIST_W'(1);
					end
					state_q <= S_ADD_TOT;
				end
				S_ADD_TOT: begin
					total_q <= alu_sat;
					state_q <= S_IDLE;
				end
				S_Q_DEN: begin
					state_q <= S_Q_CHK;
				end
				S_Q_CHK: begin
					state_q <= alu_borrow ? S_DONE : S_Q_ADJ;
				end
				S_Q_ADJ: begin
					state_q <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					addr_q      <= category_id[AW-1:0];
					weight_q    <= weight;
					smooth_on_q <= use_smooth;
					in_range_q  <= id_in_range;
					res_q       <= category_id[ID_W-1] ? PROB_ONE : EMPTY_P;
				end
			end
			S_Q_DEN: begin
				den_q <= alu_res[DEN_W-1:0];
				num_q <= (smooth_on_q && !cnt_above) ? CNT_W'(smooth_q) : cnt_sel;
			end
			S_Q_CHK: begin
				// numerator above denominator: ratio clamps to one
				res_q <= PROB_ONE;
			end
			S_Q_ADJ: begin
				// dividend = num * 2^16 + den / 2, high part seeds the remainder
				rem_q  <= DEN_W'(alu_res[DEN_W-1:1]);
				dl_q   <= {alu_res[0], den_q[PROB_W-1:1]};
				quo_q  <= '0;
				step_q <= '0;
			end
			S_Q_DIV: begin
				rem_q  <= alu_borrow ? rem_shift[DEN_W-1:0] : alu_res[DEN_W-1:0];
				dl_q   <= {dl_q[PROB_W-2:0], 1'b0};
				quo_q  <= quo_next;
				step_q <= step_q + CNT_BW'(1);
				res_q  <= quo_clamped;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			prob_q     <= res_q;
			dist_out_q <= distinct_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign probability         = prob_q;
	assign distinct_categories = dist_out_q;

endmodule

// File: design/sch_checker.sv
// Port-level checker for the category histogram, with its bind statement.
// Depends on sch_pkg and smoothed_category_histogram_assert.svh.
`include "smoothed_category_histogram_assert.svh"

module sch_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [sch_pkg::REQ_W-1:0] req_type,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sch_pkg::PROB_W-1:0] probability
);
	import sch_pkg::*;

	// hold a stalled result beat
	`SCH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SCH_ASSERT_NEXT(a_prob_stable, clk, arst_n, out_valid && !out_ready, $stable(probability))
	// a clear starts the sweep, so the block goes busy
	`SCH_ASSERT_NEXT(a_clear_busy, clk, arst_n, in_valid && in_ready && (req_type == REQ_CLEAR), !in_ready)
	// a query always makes the block go busy
	`SCH_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && (req_type == REQ_QUERY), !in_ready)
	// a result appears only out of a busy cycle
	`SCH_ASSERT_IMPL(a_result_src, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind smoothed_category_histogram sch_checker u_sch_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.req_type    (req_type),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.probability (probability)
);

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for smoothed_category_histogram: a shadow histogram predicts every
// query answer, and randomized valid/ready traffic drives both channels. Depends on sch_pkg.
module tb;
	import sch_pkg::*;

	localparam int N_CAT = NUM_GENES_DEF;
	// The block leaves this request code unused; it must leave no trace.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		logic [PROB_W-1:0] prob;
		logic [DIST_W-1:0] n_distinct;
	} query_answer_t;

	// Shadow copy of the histogram plus the answers still owed by the block.
	class histogram_checker;
		bit [CNT_W-1:0] counts [N_CAT];
		bit [CNT_W-1:0] total;
		bit [DIST_W-1:0] distinct;
		bit [SMOOTH_W-1:0] smooth;
		query_answer_t awaited_answers [$];
		int mismatches;
		int beats_taken;
		int answers_checked;

		function new();
			wipe();
			smooth = SMOOTH_RST;
		endfunction

		function void wipe();
			foreach (counts[i])
				counts[i] = '0;
			total = '0;
			distinct = '0;
		endfunction

		function bit [CNT_W-1:0] saturating_sum(bit [CNT_W-1:0] a, bit [WEIGHT_W-1:0] b);
			bit [CNT_W:0] s;
			s = a + b;
			return s[CNT_W] ? '1 : s[CNT_W-1:0];
		endfunction

		// Round to nearest with ties up, then clamp to 1.0.
		function bit [PROB_W-1:0] rounded_fraction(bit [63:0] num, bit [63:0] den);
			bit [63:0] q;
			if (den == 0)
				return PROB_ONE;
			q = ((num << 16) + (den >> 1)) / den;
			return (q > PROB_ONE) ? PROB_ONE : q[PROB_W-1:0];
		endfunction

		function void note_config(logic [SMOOTH_W-1:0] value);
			smooth = value;
		endfunction

		// Apply one accepted request beat; queue the answer a query owes.
		function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] raw,
				logic [WEIGHT_W-1:0] w, logic sm);
			bit in_rng;
			bit [63:0] cnt;
			bit [63:0] num;
			query_answer_t ans;
			in_rng = !raw[ID_W-1] && raw < N_CAT;
			beats_taken++;
			case (req)
				REQ_CLEAR: wipe();
				REQ_ADD: if (in_rng) begin
					// Zero entries count as new, even when the weight is zero.
					if (counts[raw] == 0 && distinct != DISTINCT_MAX)
						distinct++;
					counts[raw] = saturating_sum(counts[raw], w);
					total = saturating_sum(total, w);
				end
				REQ_QUERY: begin
					if (raw[ID_W-1]) begin
						ans.prob = PROB_ONE;
					end else if (total == 0) begin
						ans.prob = rounded_fraction(1, N_CAT);
					end else begin
						cnt = in_rng ? counts[raw] : 0;
						if (sm) begin
							num = (cnt > smooth) ? cnt : smooth;
							ans.prob = rounded_fraction(num, 64'(total) + 64'(smooth));
						end else begin
							ans.prob = rounded_fraction(cnt, total);
						end
					end
					ans.n_distinct = distinct;
					awaited_answers.push_back(ans);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_answer(logic [PROB_W-1:0] prob, logic [DIST_W-1:0] n_distinct);
			query_answer_t want;
			if (awaited_answers.size() == 0) begin
				report($sformatf("answer beat p=%0d d=%0d with nothing owed", prob,
					n_distinct));
				return;
			end
			want = awaited_answers.pop_front();
			answers_checked++;
			if (prob !== want.prob)
				report($sformatf("probability %0d, want %0d", prob, want.prob));
			if (n_distinct !== want.n_distinct)
				report($sformatf("distinct_categories %0d, want %0d", n_distinct,
					want.n_distinct));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = REQ_CLEAR;
	logic signed [ID_W-1:0] category_id = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	logic use_smooth = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PROB_W-1:0] probability;
	logic [DIST_W-1:0] distinct_categories;
	logic cfg_wr_en = 1'b0;
	logic [SMOOTH_W-1:0] cfg_wr_data = '0;

	histogram_checker sb = new();

	// calm: no idling on either side. hold_left: cycles the receiver still refuses.
	bit calm = 1'b0;
	int hold_left = 0;
	int smooth_settings = 1;

	smoothed_category_histogram #(.NUM_GENES(N_CAT)) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.req_type            (req_type),
		.category_id         (category_id),
		.weight              (weight),
		.use_smooth          (use_smooth),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.probability         (probability),
		.distinct_categories (distinct_categories),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sample every handshake at the edge, before any of this edge's updates land.
	// Check answers first: an answer never belongs to a beat taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_answer(probability, distinct_categories);
			if (in_valid && in_ready)
				sb.note_request(req_type, category_id, weight, use_smooth);
			if (cfg_wr_en)
				sb.note_config(cfg_wr_data);
		end
	end

	// Receiver: random stalls, a calm stretch, and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 32);
			end
		end
	end

	// Offer one beat and hold it until taken. Called at a clock edge; returns at the
	// edge of acceptance, where the next call may drive the following beat at once.
	task automatic send_beat(input logic [REQ_W-1:0] req, input int id, input int w,
			input bit sm);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 32)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		category_id <= 16'(id);
		weight <= 16'(w);
		use_smooth <= sm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, wait until every owed answer is in and the block is idle again.
	task automatic drain_answers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_answers.size() != 0)
			@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_smooth(input logic [SMOOTH_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		smooth_settings++;
	endtask

	// Random traffic. Ids lean on a small hot set so counts build up and queries mean
	// something; the rest covers the full table, its upper boundary and raw noise.
	// Ignored beats do not count toward the target.
	task automatic run_random(input int target);
		int useful;
		int roll;
		int id;
		int w;
		logic [REQ_W-1:0] req;
		bit ignored;
		useful = 0;
		while (useful < target) begin
			roll = $urandom_range(99);
			if (roll < 1)
				req = REQ_CLEAR;
			else if (roll < 3)
				req = REQ_UNUSED;
			else if (roll < 48)
				req = REQ_ADD;
			else
				req = REQ_QUERY;
			roll = $urandom_range(99);
			if (roll < 60)
				id = $urandom_range(15);
			else if (roll < 80)
				id = $urandom_range(N_CAT - 1);
			else if (roll < 90)
				id = $urandom_range(N_CAT + 2, N_CAT - 3);
			else
				id = $urandom_range(16'hFFFF);
			roll = $urandom_range(99);
			if (roll < 70)
				w = $urandom_range(32768);
			else if (roll < 85)
				case ($urandom_range(2))
					0: w = 0;
					1: w = 32768;
					default: w = 16'hFFFF;
				endcase
			else
				w = $urandom_range(16'hFFFF);
			send_beat(req, id, w, 1'($urandom_range(1)));
			ignored = (req == REQ_UNUSED) ||
				(req == REQ_ADD && (id[ID_W-1] || id[ID_W-1:0] >= N_CAT));
			if (!ignored)
				useful++;
		end
	endtask

	initial begin
		#15_000_000;
		$display("run timed out waiting on the block");
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset smoothing floor. The sender waits out the
		// clearing sweep after reset through in_ready.
		// Empty histogram, missing ids and out-of-range ids before any sample.
		send_beat(REQ_QUERY, 5, 0, 1'b0);
		send_beat(REQ_QUERY, 5, 0, 1'b1);
		send_beat(REQ_QUERY, -1, 0, 1'b0);
		send_beat(REQ_QUERY, -32768, 0, 1'b1);
		send_beat(REQ_QUERY, 32767, 0, 1'b0);
		// Adds that must be ignored, and the unused request code.
		send_beat(REQ_ADD, -5, 100, 1'b0);
		send_beat(REQ_ADD, N_CAT, 100, 1'b0);
		send_beat(REQ_ADD, 32767, 16'hFFFF, 1'b1);
		send_beat(REQ_UNUSED, 0, 500, 1'b1);
		send_beat(REQ_QUERY, 0, 0, 1'b0);
		// Zero-weight adds bump the distinct count each time the entry is still zero.
		send_beat(REQ_ADD, 0, 32768, 1'b0);
		send_beat(REQ_ADD, N_CAT - 1, 0, 1'b0);
		send_beat(REQ_ADD, N_CAT - 1, 0, 1'b0);
		send_beat(REQ_ADD, N_CAT - 1, 16'hFFFF, 1'b0);
		send_beat(REQ_ADD, 0, 1, 1'b0);
		send_beat(REQ_QUERY, 0, 0, 1'b0);
		send_beat(REQ_QUERY, 0, 0, 1'b1);
		send_beat(REQ_QUERY, N_CAT - 1, 0, 1'b0);
		send_beat(REQ_QUERY, N_CAT - 1, 0, 1'b1);
		send_beat(REQ_QUERY, N_CAT, 0, 1'b0);
		send_beat(REQ_QUERY, N_CAT, 0, 1'b1);
		send_beat(REQ_QUERY, 500, 0, 1'b1);
		send_beat(REQ_QUERY, -1, 0, 1'b1);
		send_beat(REQ_CLEAR, 0, 0, 1'b0);
		send_beat(REQ_QUERY, 0, 0, 1'b1);
		drain_answers();

		// No floor at all.
		write_smooth(16'd0);
		run_random(240);
		drain_answers();

		// Largest floor. Hold the receiver off while the sender keeps offering, so the
		// output register fills and the block stalls its input.
		write_smooth(16'hFFFF);
		hold_left = HOLD_OFF_CYCLES;
		run_random(240);
		drain_answers();

		// Smallest nonzero floor, back-to-back traffic on both sides.
		write_smooth(16'd1);
		calm = 1'b1;
		run_random(240);
		calm = 1'b0;
		drain_answers();

		// Spread samples over the table so the distinct count climbs past the hot set.
		write_smooth(16'($urandom_range(16'hFFFF)));
		send_beat(REQ_CLEAR, 0, 0, 1'b0);
		for (int i = 0; i < N_CAT; i += 8)
			send_beat(REQ_ADD, i, $urandom_range(32768), 1'b0);
		for (int i = 0; i < 20; i++)
			send_beat(REQ_QUERY, $urandom_range(N_CAT + 1), 0, 1'($urandom_range(1)));
		run_random(240);
		drain_answers();

		write_smooth(SMOOTH_RST);
		run_random(240);
		drain_answers();

		// Heavy weights on one category, checking along the way.
		write_smooth(16'hFFFF);
		calm = 1'b1;
		send_beat(REQ_CLEAR, 0, 0, 1'b0);
		for (int i = 0; i < 64; i++) begin
			send_beat(REQ_ADD, 7, 16'hFFFF, 1'b0);
			if (i % 16 == 0)
				send_beat(REQ_QUERY, 7, 0, i[4]);
		end
		send_beat(REQ_ADD, 9, 5, 1'b0);
		send_beat(REQ_QUERY, 7, 0, 1'b0);
		send_beat(REQ_QUERY, 7, 0, 1'b1);
		send_beat(REQ_QUERY, 9, 0, 1'b0);
		send_beat(REQ_QUERY, 9, 0, 1'b1);
		send_beat(REQ_QUERY, N_CAT, 0, 1'b1);
		drain_answers();
		write_smooth(16'd0);
		send_beat(REQ_QUERY, 7, 0, 1'b1);
		send_beat(REQ_QUERY, 9, 0, 1'b1);
		calm = 1'b0;
		drain_answers();

		if (sb.awaited_answers.size() != 0)
			sb.report($sformatf("%0d answers never arrived", sb.awaited_answers.size()));
		$display("covered %0d request beats and %0d checked answers, incl. heavy weights",
			sb.beats_taken, sb.answers_checked);
		$display("smoothing floor took %0d settings, 0 and 65535 among them", smooth_settings);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
